// ===== rtl/lcdfb_pkg.sv =====
package lcdfb_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_FILL    = 2'd1,
    OP_INIT    = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_ON = 2'd0,
    REG_SET_COLUMN = 2'd1,
    REG_SET_PAGE   = 2'd2,
    REG_START_LINE = 2'd3
  } reg_idx_t;

  localparam logic [1:0] CS_LEFT  = 2'd1;
  localparam logic [1:0] CS_RIGHT = 2'd2;
  localparam logic [1:0] CS_BOTH  = 2'd3;

  localparam logic [7:0] RST_DISPLAY_ON = 8'd63;
  localparam logic [7:0] RST_SET_COLUMN = 8'd64;
  localparam logic [7:0] RST_SET_PAGE   = 8'd184;
  localparam logic [7:0] RST_START_LINE = 8'd192;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] display_on;
    logic [7:0] set_column;
    logic [7:0] set_page;
    logic [7:0] start_line;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic       pixel_on;
    logic [2:0] bit_sel;
    logic [7:0] fill_byte;
  } cmd_t;

  typedef struct packed {
    logic       is_data;
    logic [1:0] chip_select;
    logic [7:0] bus_byte;
    logic       last_of_run;
    logic       frame_done;
  } res_t;

endpackage

// ===== rtl/dual_controller_lcd_framebuffer.sv =====
// Channel   Handshake             Payload
// in_       in_valid/in_ready     kind, pixel_on, x_coord, y_coord, fill_byte
// out_      out_valid/out_ready   is_data, chip_select, bus_byte, last_of_run, frame_done
// apb       psel/penable/pwrite   paddr, pwdata, prdata, pready (always 1)
//
// Pixel item: queue pop with store read, then write back.
// Refresh step: queue pop, then an instruction result, or for a data byte a registered store read and then the result.
// Init item: queue pop, then four results through the single output register.
// Fill item and reset: one store entry per cycle over 2 << (clog2(PAGES) + clog2(HALF_WIDTH))
// entries (1024 by default); in_ready is low during that sweep.
// A stalled output holds the back end when it has a result to send; the front queue keeps accepting until full.
module dual_controller_lcd_framebuffer #(
  parameter int PAGES      = 8,
  parameter int HALF_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic               in_pixel_on,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic [7:0]         in_fill_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_data,
  output logic [1:0]         out_chip_select,
  output logic [7:0]         out_bus_byte,
  output logic               out_last_of_run,
  output logic               out_frame_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;
  localparam int AW = 1 + PW + CW;
  localparam int QW = AW + $bits(lcdfb_pkg::cmd_t);

  lcdfb_pkg::cfg_t cfg_r, cfg_nxt;
  lcdfb_pkg::cmd_t f_cmd, b_cmd;
  logic [AW-1:0]   f_addr, b_addr;
  logic            q_push, q_pop, q_full, q_empty, clearing;
  logic [QW-1:0]   q_rd;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (lcdfb_pkg::reg_idx_t'(paddr[3:2]))
        lcdfb_pkg::REG_DISPLAY_ON: cfg_nxt.display_on = pwdata[7:0];
        lcdfb_pkg::REG_SET_COLUMN: cfg_nxt.set_column = pwdata[7:0];
        lcdfb_pkg::REG_SET_PAGE:   cfg_nxt.set_page   = pwdata[7:0];
        lcdfb_pkg::REG_START_LINE: cfg_nxt.start_line = pwdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (lcdfb_pkg::reg_idx_t'(paddr[3:2]))
      lcdfb_pkg::REG_DISPLAY_ON: prdata = 32'(cfg_r.display_on);
      lcdfb_pkg::REG_SET_COLUMN: prdata = 32'(cfg_r.set_column);
      lcdfb_pkg::REG_SET_PAGE:   prdata = 32'(cfg_r.set_page);
      lcdfb_pkg::REG_START_LINE: prdata = 32'(cfg_r.start_line);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_on <= lcdfb_pkg::RST_DISPLAY_ON;
      cfg_r.set_column <= lcdfb_pkg::RST_SET_COLUMN;
      cfg_r.set_page   <= lcdfb_pkg::RST_SET_PAGE;
      cfg_r.start_line <= lcdfb_pkg::RST_START_LINE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcdfb_front #(.PAGES(PAGES), .HALF_WIDTH(HALF_WIDTH), .AW(AW)) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_pixel_on  (in_pixel_on),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .in_fill_byte (in_fill_byte),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (f_cmd),
    .q_addr       (f_addr)
  );

  lcdfb_queue #(.WIDTH(QW), .DEPTH(lcdfb_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_addr, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  assign b_addr = q_rd[QW-1 -: AW];
  assign b_cmd  = lcdfb_pkg::cmd_t'(q_rd[$bits(lcdfb_pkg::cmd_t)-1:0]);

  lcdfb_back #(.PAGES(PAGES), .HALF_WIDTH(HALF_WIDTH), .AW(AW)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_cmd           (b_cmd),
    .q_addr          (b_addr),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_data     (out_is_data),
    .out_chip_select (out_chip_select),
    .out_bus_byte    (out_bus_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input accepted during store sweep");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> clearing && !out_valid)
    else $error("no clearing sweep after reset");

  a_frame_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |->
      out_is_data && out_last_of_run && (out_chip_select == lcdfb_pkg::CS_RIGHT))
    else $error("frame end not on a right-half data write");

  a_cs_vs_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_data ? (out_chip_select != lcdfb_pkg::CS_BOTH)
                               : (out_chip_select == lcdfb_pkg::CS_BOTH)))
    else $error("chip select does not match transfer type");
`endif

endmodule

// ===== rtl/lcdfb_ram.sv =====
module lcdfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lcdfb_queue.sv =====
module lcdfb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/lcdfb_front.sv =====
module lcdfb_front #(
  parameter int PAGES      = 8,
  parameter int HALF_WIDTH = 64,
  parameter int AW         = 10
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic               in_pixel_on,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic [7:0]         in_fill_byte,
  input  logic               clearing,
  input  logic               q_full,
  output logic               q_push,
  output lcdfb_pkg::cmd_t    q_cmd,
  output logic [AW-1:0]      q_addr
);

  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;

  logic [15:0]   x_u, y_u, x_off;
  logic          x_ok, y_ok, half;
  logic [CW-1:0] col;
  logic [PW-1:0] page;

  assign x_u   = $unsigned(in_x_coord);
  assign y_u   = $unsigned(in_y_coord);
  assign x_ok  = !x_u[15] && (x_u < 16'(2 * HALF_WIDTH));
  assign y_ok  = !y_u[15] && (y_u < 16'(PAGES * 8));
  assign half  = (x_u >= 16'(HALF_WIDTH));
  assign x_off = x_u - 16'(HALF_WIDTH);
  assign col   = half ? x_off[CW-1:0] : x_u[CW-1:0];
  assign page  = y_u[3 +: PW];

  assign in_ready = !q_full && !clearing;

  always_comb begin
    q_cmd.op        = lcdfb_pkg::op_t'(in_kind);
    q_cmd.pixel_on  = in_pixel_on;
    q_cmd.bit_sel   = y_u[2:0];
    q_cmd.fill_byte = in_fill_byte;
    q_addr          = {half, page, col};
    q_push          = in_valid && in_ready &&
                      ((q_cmd.op != lcdfb_pkg::OP_PIXEL) || (x_ok && y_ok));
  end

endmodule

// ===== rtl/lcdfb_back.sv =====
module lcdfb_back #(
  parameter int PAGES      = 8,
  parameter int HALF_WIDTH = 64,
  parameter int AW         = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lcdfb_pkg::cfg_t cfg,
  input  logic            q_empty,
  input  lcdfb_pkg::cmd_t q_cmd,
  input  logic [AW-1:0]   q_addr,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_is_data,
  output logic [1:0]      out_chip_select,
  output logic [7:0]      out_bus_byte,
  output logic            out_last_of_run,
  output logic            out_frame_done
);

  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW     = (HALF_WIDTH > 1) ? $clog2(HALF_WIDTH) : 1;
  localparam int STEPS  = 2 + 2 * HALF_WIDTH;
  localparam int STEP_W = $clog2(STEPS);
  localparam int DEPTH  = 1 << AW;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_PIXWR   = 6'b000100,
    ST_INIT    = 6'b001000,
    ST_REF     = 6'b010000,
    ST_REFDATA = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [7:0]        fill_val_r, fill_val_nxt;
  logic [AW-1:0]     pix_addr_r, pix_addr_nxt;
  logic [2:0]        pix_bit_r, pix_bit_nxt;
  logic              pix_on_r, pix_on_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [PW-1:0]     page_r, page_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  lcdfb_pkg::res_t   res_r, res_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata, mask;

  logic              slot_free, scan_half, scan_done;
  logic [STEP_W-1:0] scan_d, scan_d_off, scan_col_full;
  logic [CW-1:0]     scan_col;
  logic [PW-1:0]     adv_page;
  logic [STEP_W-1:0] adv_step;
  logic [7:0]        init_byte;

  lcdfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free     = !ovalid_r || out_ready;
  assign mask          = 8'(1) << pix_bit_r;
  assign scan_d        = step_r - STEP_W'(2);
  assign scan_half     = (scan_d >= STEP_W'(HALF_WIDTH));
  assign scan_d_off    = scan_d - STEP_W'(HALF_WIDTH);
  assign scan_col_full = scan_half ? scan_d_off : scan_d;
  assign scan_col      = scan_col_full[CW-1:0];
  assign scan_done     = (step_r == STEP_W'(STEPS - 1)) && (page_r == PW'(PAGES - 1));

  always_comb begin
    adv_page = page_r;
    adv_step = step_r + 1'b1;
    if (step_r == STEP_W'(STEPS - 1)) begin
      adv_step = '0;
      adv_page = (page_r == PW'(PAGES - 1)) ? '0 : page_r + 1'b1;
    end
  end

  always_comb begin
    case (lcdfb_pkg::reg_idx_t'(cnt_r))
      lcdfb_pkg::REG_DISPLAY_ON: init_byte = cfg.display_on;
      lcdfb_pkg::REG_SET_COLUMN: init_byte = cfg.set_column;
      lcdfb_pkg::REG_SET_PAGE:   init_byte = cfg.set_page;
      lcdfb_pkg::REG_START_LINE: init_byte = cfg.start_line;
      default:                   init_byte = cfg.display_on;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    fill_val_nxt = fill_val_r;
    pix_addr_nxt = pix_addr_r;
    pix_bit_nxt  = pix_bit_r;
    pix_on_nxt   = pix_on_r;
    cnt_nxt      = cnt_r;
    page_nxt     = page_r;
    step_nxt     = step_r;
    res_nxt      = res_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = sweep_r;
    ram_wdata    = fill_val_r;
    ram_re       = 1'b0;
    ram_raddr    = {scan_half, page_r, scan_col};
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            lcdfb_pkg::OP_PIXEL: begin
              ram_re       = 1'b1;
              ram_raddr    = q_addr;
              pix_addr_nxt = q_addr;
              pix_bit_nxt  = q_cmd.bit_sel;
              pix_on_nxt   = q_cmd.pixel_on;
              state_nxt    = ST_PIXWR;
            end
            lcdfb_pkg::OP_FILL: begin
              fill_val_nxt = q_cmd.fill_byte;
              sweep_nxt    = '0;
              state_nxt    = ST_CLEAR;
            end
            lcdfb_pkg::OP_INIT: begin
              cnt_nxt   = '0;
              page_nxt  = '0;
              step_nxt  = '0;
              state_nxt = ST_INIT;
            end
            lcdfb_pkg::OP_REFRESH: begin
              state_nxt = ST_REF;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIXWR: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr_r;
        ram_wdata = pix_on_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        if (slot_free) begin
          ovalid_nxt          = 1'b1;
          res_nxt.is_data     = 1'b0;
          res_nxt.chip_select = lcdfb_pkg::CS_BOTH;
          res_nxt.bus_byte    = init_byte;
          res_nxt.last_of_run = (cnt_r == lcdfb_pkg::REG_START_LINE);
          res_nxt.frame_done  = 1'b0;
          cnt_nxt             = cnt_r + 1'b1;
          if (cnt_r == lcdfb_pkg::REG_START_LINE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REF: begin
        if (step_r >= STEP_W'(2)) begin
          ram_re    = 1'b1;
          state_nxt = ST_REFDATA;
        end else if (slot_free) begin
          ovalid_nxt          = 1'b1;
          res_nxt.is_data     = 1'b0;
          res_nxt.chip_select = lcdfb_pkg::CS_BOTH;
          res_nxt.bus_byte    = (step_r == '0) ? cfg.set_column
                                               : (cfg.set_page | 8'(page_r));
          res_nxt.last_of_run = 1'b1;
          res_nxt.frame_done  = 1'b0;
          page_nxt            = adv_page;
          step_nxt            = adv_step;
          state_nxt           = ST_IDLE;
        end
      end
      ST_REFDATA: begin
        if (slot_free) begin
          ovalid_nxt          = 1'b1;
          res_nxt.is_data     = 1'b1;
          res_nxt.chip_select = scan_half ? lcdfb_pkg::CS_RIGHT : lcdfb_pkg::CS_LEFT;
          res_nxt.bus_byte    = ram_rdata;
          res_nxt.last_of_run = 1'b1;
          res_nxt.frame_done  = scan_done;
          page_nxt            = adv_page;
          step_nxt            = adv_step;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      sweep_r    <= '0;
      fill_val_r <= '0;
      cnt_r      <= '0;
      page_r     <= '0;
      step_r     <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      fill_val_r <= fill_val_nxt;
      cnt_r      <= cnt_nxt;
      page_r     <= page_nxt;
      step_r     <= step_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_addr_r <= pix_addr_nxt;
    pix_bit_r  <= pix_bit_nxt;
    pix_on_r   <= pix_on_nxt;
    res_r      <= res_nxt;
  end

  assign clearing        = (state_r == ST_CLEAR);
  assign out_valid       = ovalid_r;
  assign out_is_data     = res_r.is_data;
  assign out_chip_select = res_r.chip_select;
  assign out_bus_byte    = res_r.bus_byte;
  assign out_last_of_run = res_r.last_of_run;
  assign out_frame_done  = res_r.frame_done;

endmodule
